### design/avtc_pkg.sv
// ----------------------------------------------------------------------------
// avtc_pkg
// Shared types, constants and helpers for the A/V timestamp corrector.
// ----------------------------------------------------------------------------
package avtc_pkg;

   localparam int TS_W    = 32;   // raw and output timestamp width
   localparam int CSR_W   = 16;   // configuration register width
   localparam int DELTA_W = TS_W + 1;  // signed difference of two timestamps
   localparam int STEP_W  = CSR_W + 1; // signed chosen step
   localparam int FIXED_W = 63;   // corrected clock, 0 .. 2^63-1

   localparam logic [FIXED_W-1:0] FIXED_MAX = {FIXED_W{1'b1}};

   // packet kinds; code three is treated like other
   typedef enum logic [1:0] {
      KIND_VIDEO = 2'd0,
      KIND_AUDIO = 2'd1,
      KIND_OTHER = 2'd2
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_VIDEO_LIMIT   = 2'd0,
      CSR_VIDEO_DEFAULT = 2'd1,
      CSR_AUDIO_LIMIT   = 2'd2,
      CSR_AUDIO_DEFAULT = 2'd3
   } csr_index_type;

   // one correction step: raw difference and the limits that judge it
   typedef struct packed {
      logic [DELTA_W-1:0] delta;   // two's complement
      logic [CSR_W-1:0]   limit;
      logic [CSR_W-1:0]   dflt;
   } step_ctrl_type;

   // true when -lim < d < lim (open window)
   function automatic logic in_window(input logic signed [DELTA_W:0] d,
                                      input logic [CSR_W-1:0] lim);
      logic signed [DELTA_W:0] lim_s;
      lim_s = $signed({{(DELTA_W + 1 - CSR_W){1'b0}}, lim});
      return (d > -lim_s) && (d < lim_s);
   endfunction

endpackage

### design/avtc_step.sv
// ----------------------------------------------------------------------------
// avtc_step
// Picks the step for one packet (raw delta or default) and advances a
// corrected clock by it, clamping at zero and saturating at the top.
// ----------------------------------------------------------------------------
module avtc_step (
   input  avtc_pkg::step_ctrl_type           ctrl,
   input  logic [avtc_pkg::FIXED_W-1:0]      base,
   output logic [avtc_pkg::FIXED_W-1:0]      result
);

   logic                                in_range;
   logic [avtc_pkg::STEP_W-1:0]         step;
   logic [avtc_pkg::FIXED_W:0]          sum;

   // delta is kept only if it sits strictly inside the limit window
   assign in_range = avtc_pkg::in_window(
      $signed({ctrl.delta[avtc_pkg::DELTA_W-1], ctrl.delta}), ctrl.limit);
   assign step = in_range ? ctrl.delta[avtc_pkg::STEP_W-1:0]
                          : {1'b0, ctrl.dflt};

   // base is below 2^63, so bit 63 of the sum flags underflow or overflow
   assign sum = {1'b0, base}
              + {{(avtc_pkg::FIXED_W + 1 - avtc_pkg::STEP_W){step[avtc_pkg::STEP_W-1]}},
                 step};

   always_comb begin
      if (sum[avtc_pkg::FIXED_W]) begin
         result = step[avtc_pkg::STEP_W-1] ? '0 : avtc_pkg::FIXED_MAX;
      end else begin
         result = sum[avtc_pkg::FIXED_W-1:0];
      end
   end

endmodule

### design/av_timestamp_corrector_unit.sv
// ----------------------------------------------------------------------------
// av_timestamp_corrector_unit
// Repairs timestamps of an interleaved audio/video packet stream.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (packet kind, codec-header flag, raw timestamp) enter on the
//   req_ channel; one corrected timestamp per request leaves on rsp_.
//   A request is taken when req_valid is high and req_stall low; the
//   result is taken when rsp_valid is high and rsp_stall low.
//   The request loads the input register; the correction result is then
//   loaded into the result register when the stage advances.
//   Throughput: one request per cycle while the receiver does not stall;
//   the whole correction (delta, window check, clamp, state update) is one
//   pass of logic between the input and result registers.
//   Receiver stall: the result register holds; the input register still
//   fills while it is empty, then req_stall rises until rsp drains.
//   Reset (synchronous) drops both registers, clears the stream history
//   and loads the default limits (100/40 video, 100/20 audio).
//   csr_ writes load the four limit registers; write only while idle.
// ----------------------------------------------------------------------------
module av_timestamp_corrector_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_packet_kind,
   input  logic                          req_codec_header,
   input  logic [avtc_pkg::TS_W-1:0]     req_raw_timestamp,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [avtc_pkg::TS_W-1:0]     rsp_fixed_timestamp,
   // configuration port
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [avtc_pkg::CSR_W-1:0]    csr_write_data
);

   localparam logic [1:0] ASV_MAX = 2'd2;

   // configuration registers
   logic [avtc_pkg::CSR_W-1:0] vlim_ff, vdef_ff, alim_ff, adef_ff;

   // input stage
   logic                       st_valid_ff, st_valid_in;
   logic [1:0]                 st_kind_ff;
   logic                       st_hdr_ff;
   logic [avtc_pkg::TS_W-1:0]  st_ts_ff;

   // result stage
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [avtc_pkg::TS_W-1:0]  rsp_ts_ff, rsp_ts_in;

   // stream history
   logic                          vseen_ff, vseen_in;
   logic [avtc_pkg::TS_W-1:0]     vraw_ff, vraw_in;
   logic [avtc_pkg::FIXED_W-1:0]  vfixed_ff, vfixed_in;
   logic                          aseen_ff, aseen_in;
   logic [avtc_pkg::TS_W-1:0]     araw_ff, araw_in;
   logic [avtc_pkg::FIXED_W-1:0]  afixed_ff, afixed_in;
   logic [1:0]                    asv_ff, asv_in;

   // handshake
   logic adv, req_fire, st_fire;

   // datapath
   logic                          is_video, is_audio, audio_start;
   logic [avtc_pkg::DELTA_W-1:0]  dv, da;
   logic [avtc_pkg::TS_W-1:0]     anchor_diff;
   logic                          reanchor;
   avtc_pkg::step_ctrl_type       ctrl;
   logic [avtc_pkg::FIXED_W-1:0]  base, stepped, new_fixed;

   // flow control: stage moves when the result register is free
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = st_valid_ff && !adv;
   assign req_fire  = req_valid && !req_stall;
   assign st_fire   = st_valid_ff && adv;

   assign st_valid_in  = req_fire ? 1'b1 : (st_fire ? 1'b0 : st_valid_ff);
   assign rsp_valid_in = adv ? st_fire : rsp_valid_ff;

   // packet decode
   assign is_video = !st_hdr_ff && (st_kind_ff == avtc_pkg::KIND_VIDEO);
   assign is_audio = !st_hdr_ff && (st_kind_ff == avtc_pkg::KIND_AUDIO);

   // raw differences against both histories, in parallel
   assign dv = {1'b0, st_ts_ff} - {1'b0, vraw_ff};
   assign da = {1'b0, st_ts_ff} - {1'b0, araw_ff};

   // first video: restart from the audio clock if audio is far off
   assign anchor_diff = araw_ff - st_ts_ff;
   assign reanchor = aseen_ff && !avtc_pkg::in_window(
      $signed({{2{anchor_diff[avtc_pkg::TS_W-1]}}, anchor_diff}), vlim_ff);

   // audio without a reference starts its own clock at the raw time
   assign audio_start = is_audio && ((asv_ff != 2'd0) ? !aseen_ff : !vseen_ff);

   // pick the history and limits for this packet
   always_comb begin
      ctrl.limit = vlim_ff;
      ctrl.dflt  = vdef_ff;
      ctrl.delta = dv;
      base       = vfixed_ff;
      if (is_video) begin
         if (!vseen_ff) begin
            if (reanchor) begin
               ctrl.delta = da;
               base       = afixed_ff;
            end else begin
               ctrl.delta = '0;
               base       = {{(avtc_pkg::FIXED_W - avtc_pkg::TS_W){1'b0}}, st_ts_ff};
            end
         end
      end else if (asv_ff != 2'd0) begin
         // later audio runs on its own delta
         ctrl.limit = alim_ff;
         ctrl.dflt  = adef_ff;
         ctrl.delta = da;
         base       = afixed_ff;
      end
   end

   avtc_step u_step (
      .ctrl   (ctrl),
      .base   (base),
      .result (stepped)
   );

   assign new_fixed = audio_start
                    ? {{(avtc_pkg::FIXED_W - avtc_pkg::TS_W){1'b0}}, st_ts_ff}
                    : stepped;

   // result and history updates
   always_comb begin
      rsp_ts_in = rsp_ts_ff;
      vseen_in  = vseen_ff;
      vraw_in   = vraw_ff;
      vfixed_in = vfixed_ff;
      aseen_in  = aseen_ff;
      araw_in   = araw_ff;
      afixed_in = afixed_ff;
      asv_in    = asv_ff;
      if (st_fire) begin
         rsp_ts_in = (is_video || is_audio) ? new_fixed[avtc_pkg::TS_W-1:0] : '0;
         if (is_video) begin
            vseen_in  = 1'b1;
            vraw_in   = st_ts_ff;
            vfixed_in = new_fixed;
            asv_in    = 2'd0;
         end else if (is_audio) begin
            aseen_in  = 1'b1;
            araw_in   = st_ts_ff;
            afixed_in = new_fixed;
            asv_in    = (asv_ff == ASV_MAX) ? ASV_MAX : asv_ff + 2'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vseen_ff     <= 1'b0;
         vraw_ff      <= '0;
         vfixed_ff    <= '0;
         aseen_ff     <= 1'b0;
         araw_ff      <= '0;
         afixed_ff    <= '0;
         asv_ff       <= 2'd0;
      end else begin
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         vseen_ff     <= vseen_in;
         vraw_ff      <= vraw_in;
         vfixed_ff    <= vfixed_in;
         aseen_ff     <= aseen_in;
         araw_ff      <= araw_in;
         afixed_ff    <= afixed_in;
         asv_ff       <= asv_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vlim_ff <= 16'd100;
         vdef_ff <= 16'd40;
         alim_ff <= 16'd100;
         adef_ff <= 16'd20;
      end else if (csr_write_enable) begin
         case (csr_index)
            avtc_pkg::CSR_VIDEO_LIMIT:   vlim_ff <= csr_write_data;
            avtc_pkg::CSR_VIDEO_DEFAULT: vdef_ff <= csr_write_data;
            avtc_pkg::CSR_AUDIO_LIMIT:   alim_ff <= csr_write_data;
            avtc_pkg::CSR_AUDIO_DEFAULT: adef_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         st_kind_ff <= req_packet_kind;
         st_hdr_ff  <= req_codec_header;
         st_ts_ff   <= req_raw_timestamp;
      end
      rsp_ts_ff <= rsp_ts_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fixed_timestamp = rsp_ts_ff;

endmodule
